@@ rtl/gzhp_pkg.sv @@
package gzhp_pkg;

    // Default width of the byte position and member length counters
    localparam int LENGTH_BITS_DEFAULT = 32;

    // Fixed field widths of the result
    localparam int OFFSET_W = 32;
    localparam int ERROR_W  = 4;
    localparam int WORD_W   = 32;

    // One result transaction
    typedef struct packed {
        logic                payload_valid;
        logic [7:0]          payload_byte;
        logic [OFFSET_W-1:0] payload_offset;
        logic [ERROR_W-1:0]  latched_err;
        logic                member_done;
        logic [WORD_W-1:0]   expected_crc;
        logic [WORD_W-1:0]   expected_size;
    } gzhp_result_t;

endpackage

@@ rtl/gzhp_core.sv @@
module gzhp_core #(
    parameter int LENGTH_BITS = gzhp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic [LENGTH_BITS-1:0] member_length,
    output gzhp_pkg::gzhp_result_t result
);
    import gzhp_pkg::*;

    localparam int LB = LENGTH_BITS;

    // Parse phases
    localparam logic [3:0] PH_MAGIC0  = 4'd0;
    localparam logic [3:0] PH_MAGIC1  = 4'd1;
    localparam logic [3:0] PH_METHOD  = 4'd2;
    localparam logic [3:0] PH_FLAGS   = 4'd3;
    localparam logic [3:0] PH_FIXED   = 4'd4;
    localparam logic [3:0] PH_XLEN_LO = 4'd5;
    localparam logic [3:0] PH_XLEN_HI = 4'd6;
    localparam logic [3:0] PH_EXTRA   = 4'd7;
    localparam logic [3:0] PH_NAME    = 4'd8;
    localparam logic [3:0] PH_COMMENT = 4'd9;
    localparam logic [3:0] PH_HCRC    = 4'd10;
    localparam logic [3:0] PH_PAYLOAD = 4'd11;
    localparam logic [3:0] PH_TRAILER = 4'd12;
    localparam logic [3:0] PH_IDLE    = 4'd13;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_SHORT      = 4'd1;
    localparam logic [3:0] ERR_MAGIC      = 4'd2;
    localparam logic [3:0] ERR_RSVD_FLAGS = 4'd3;
    localparam logic [3:0] ERR_XLEN       = 4'd4;
    localparam logic [3:0] ERR_EXTRA      = 4'd5;
    localparam logic [3:0] ERR_NAME       = 4'd6;
    localparam logic [3:0] ERR_COMMENT    = 4'd7;
    localparam logic [3:0] ERR_HCRC       = 4'd8;
    localparam logic [3:0] ERR_NO_PAYLOAD = 4'd9;

    // Header bytes and flag masks
    localparam logic [7:0] MAGIC0_BYTE   = 8'h1F;
    localparam logic [7:0] MAGIC1_BYTE   = 8'h8B;
    localparam logic [7:0] METHOD_DEFL   = 8'h08;
    localparam logic [7:0] FLAGS_RSVD    = 8'hE0;
    localparam int         FLG_FHCRC     = 1;
    localparam int         FLG_FEXTRA    = 2;
    localparam int         FLG_FNAME     = 3;
    localparam int         FLG_FCOMMENT  = 4;
    localparam int         MIN_MEMBER    = 18;
    localparam int         FIXED_END     = 10;
    localparam int         TRAILER_BYTES = 8;

    // Outcome of picking the next optional header section
    typedef struct packed {
        logic [3:0] phase;
        logic [3:0] err;
        logic       set_skip;
        logic       set_hend;
    } section_t;

    // Walk the optional sections from 'stage' on, first one whose flag is set
    function automatic section_t enter_section(
        input logic [3:0] stage,
        input logic [4:0] flg,
        input logic       rz,
        input logic       r2
    );
        section_t r;
        logic     found;
        r     = '{phase: PH_IDLE, err: ERR_NONE, set_skip: 1'b0, set_hend: 1'b0};
        found = 1'b0;
        if (stage == PH_XLEN_LO && flg[FLG_FEXTRA]) begin
            found = 1'b1;
            if (r2) r.err = ERR_XLEN;
            else    r.phase = PH_XLEN_LO;
        end
        if (!found && stage <= PH_NAME && flg[FLG_FNAME]) begin
            found = 1'b1;
            if (rz) r.err = ERR_NAME;
            else    r.phase = PH_NAME;
        end
        if (!found && stage <= PH_COMMENT && flg[FLG_FCOMMENT]) begin
            found = 1'b1;
            if (rz) r.err = ERR_COMMENT;
            else    r.phase = PH_COMMENT;
        end
        if (!found && stage <= PH_HCRC && flg[FLG_FHCRC]) begin
            found = 1'b1;
            if (r2) begin
                r.err = ERR_HCRC;
            end else begin
                r.phase    = PH_HCRC;
                r.set_skip = 1'b1;
            end
        end
        if (!found) begin
            if (rz) begin
                r.err = ERR_NO_PAYLOAD;
            end else begin
                r.phase    = PH_PAYLOAD;
                r.set_hend = 1'b1;
            end
        end
        return r;
    endfunction

    // State registers
    logic [LB-1:0] pos_reg,   pos_next;
    logic [3:0]    phase_reg, phase_next;
    logic [4:0]    flags_reg, flags_next;
    logic [15:0]   skip_reg,  skip_next;
    logic [7:0]    xlo_reg,   xlo_next;
    logic [LB-1:0] hend_reg,  hend_next;
    logic [63:0]   trl_reg,   trl_next;
    logic [3:0]    err_reg,   err_next;

    // State as seen by this byte, after an optional restart
    logic [LB-1:0] pos_eff;
    logic [3:0]    phase_eff;
    logic [4:0]    flags_eff;
    logic [15:0]   skip_eff;
    logic [7:0]    xlo_eff;
    logic [LB-1:0] hend_eff;
    logic [63:0]   trl_eff;
    logic [3:0]    err_eff;

    logic [LB-1:0] off;
    logic [LB:0]   off_plus1;
    logic [LB-1:0] lim;
    logic [LB-1:0] room;
    logic [LB-1:0] trl_dist;
    logic [2:0]    trl_idx;
    logic          rz;
    logic          r2;
    logic [15:0]   xlen;
    logic          do_enter;
    logic [3:0]    enter_stage;
    section_t      sec;
    logic [3:0]    fail_code;
    logic          valid;
    logic          done;
    logic          idle;

    always_comb begin
        // restart on the first byte mark
        if (first_byte) begin
            pos_eff   = '0;
            phase_eff = PH_MAGIC0;
            flags_eff = '0;
            skip_eff  = '0;
            xlo_eff   = '0;
            hend_eff  = '0;
            trl_eff   = '0;
            err_eff   = ERR_NONE;
        end else begin
            pos_eff   = pos_reg;
            phase_eff = phase_reg;
            flags_eff = flags_reg;
            skip_eff  = skip_reg;
            xlo_eff   = xlo_reg;
            hend_eff  = hend_reg;
            trl_eff   = trl_reg;
            err_eff   = err_reg;
        end

        // distances to the start of the trailer
        off       = pos_eff + LB'(1);
        off_plus1 = {1'b0, off} + (LB+1)'(1);
        lim       = (member_length >= LB'(TRAILER_BYTES)) ?
                    member_length - LB'(TRAILER_BYTES) : '0;
        rz        = (lim <= off);
        r2        = ({1'b0, lim} <= off_plus1);
        room      = rz ? '0 : lim - off;
        trl_dist  = pos_eff - lim;
        trl_idx   = (pos_eff >= lim) ? trl_dist[2:0] : 3'd0;
        xlen      = {data_byte, xlo_eff};

        pos_next    = off;
        phase_next  = phase_eff;
        flags_next  = flags_eff;
        skip_next   = skip_eff;
        xlo_next    = xlo_eff;
        hend_next   = hend_eff;
        trl_next    = trl_eff;
        err_next    = err_eff;
        do_enter    = 1'b0;
        enter_stage = PH_PAYLOAD;
        fail_code   = ERR_NONE;
        valid       = 1'b0;
        done        = 1'b0;
        idle        = 1'b0;

        // per-phase byte handling
        case (phase_eff)
            PH_MAGIC0: begin
                if (member_length < LB'(MIN_MEMBER)) fail_code = ERR_SHORT;
                else if (data_byte != MAGIC0_BYTE)   fail_code = ERR_MAGIC;
                else                                 phase_next = PH_MAGIC1;
            end
            PH_MAGIC1: begin
                if (data_byte != MAGIC1_BYTE) fail_code = ERR_MAGIC;
                else                          phase_next = PH_METHOD;
            end
            PH_METHOD: begin
                if (data_byte != METHOD_DEFL) fail_code = ERR_MAGIC;
                else                          phase_next = PH_FLAGS;
            end
            PH_FLAGS: begin
                if ((data_byte & FLAGS_RSVD) != 8'd0) begin
                    fail_code = ERR_RSVD_FLAGS;
                end else begin
                    flags_next = data_byte[4:0];
                    phase_next = PH_FIXED;
                end
            end
            PH_FIXED: begin
                if (off >= LB'(FIXED_END)) begin
                    do_enter    = 1'b1;
                    enter_stage = PH_XLEN_LO;
                end
            end
            PH_XLEN_LO: begin
                xlo_next   = data_byte;
                phase_next = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                if (LB'(xlen) > room) begin
                    fail_code = ERR_EXTRA;
                end else if (xlen == 16'd0) begin
                    do_enter    = 1'b1;
                    enter_stage = PH_NAME;
                end else begin
                    skip_next  = xlen;
                    phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA: begin
                if (skip_eff <= 16'd1) begin
                    skip_next   = '0;
                    do_enter    = 1'b1;
                    enter_stage = PH_NAME;
                end else begin
                    skip_next = skip_eff - 16'd1;
                end
            end
            PH_NAME: begin
                if (data_byte == 8'd0) begin
                    do_enter    = 1'b1;
                    enter_stage = PH_COMMENT;
                end else if (rz) begin
                    fail_code = ERR_NAME;
                end
            end
            PH_COMMENT: begin
                if (data_byte == 8'd0) begin
                    do_enter    = 1'b1;
                    enter_stage = PH_HCRC;
                end else if (rz) begin
                    fail_code = ERR_COMMENT;
                end
            end
            PH_HCRC: begin
                if (skip_eff <= 16'd1) begin
                    skip_next   = '0;
                    do_enter    = 1'b1;
                    enter_stage = PH_PAYLOAD;
                end else begin
                    skip_next = skip_eff - 16'd1;
                end
            end
            PH_PAYLOAD: begin
                valid = 1'b1;
                if (rz) phase_next = PH_TRAILER;
            end
            PH_TRAILER: begin
                trl_next[trl_idx*8 +: 8] = data_byte;
                if (off >= member_length) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                // member over: bytes are ignored, state holds
                idle = 1'b1;
            end
        endcase

        // next header section
        sec = enter_section(enter_stage, flags_next, rz, r2);
        if (do_enter) begin
            if (sec.err != ERR_NONE) begin
                fail_code = sec.err;
            end else begin
                phase_next = sec.phase;
                if (sec.set_skip) skip_next = 16'd2;
                if (sec.set_hend) hend_next = off;
            end
        end

        // first error wins and ends the member
        if (fail_code != ERR_NONE) begin
            if (err_eff == ERR_NONE) err_next = fail_code;
            phase_next = PH_IDLE;
        end
        if (err_next != err_eff) done = 1'b1;

        if (idle) begin
            pos_next   = pos_eff;
            phase_next = phase_eff;
        end

        // result
        result.payload_valid  = valid;
        result.payload_byte   = valid ? data_byte : 8'd0;
        result.payload_offset = idle ? '0 : OFFSET_W'(hend_next);
        result.latched_err    = err_next;
        result.member_done    = done;
        if (done && err_next == ERR_NONE) begin
            result.expected_crc  = trl_next[31:0];
            result.expected_size = trl_next[63:32];
        end else begin
            result.expected_crc  = '0;
            result.expected_size = '0;
        end
    end

    // state update on each processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_MAGIC0;
            flags_reg <= '0;
            skip_reg  <= '0;
            xlo_reg   <= '0;
            hend_reg  <= '0;
            trl_reg   <= '0;
            err_reg   <= ERR_NONE;
        end else if (step_en) begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            skip_reg  <= skip_next;
            xlo_reg   <= xlo_next;
            hend_reg  <= hend_next;
            trl_reg   <= trl_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ rtl/gzhp_out_buf.sv @@
module gzhp_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  gzhp_pkg::gzhp_result_t load_data,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gzhp_pkg::gzhp_result_t out_data
);
    import gzhp_pkg::*;

    logic         valid_reg, valid_next;
    gzhp_result_t data_reg;

    // slot frees up when the held transaction is taken
    assign can_load = !valid_reg || out_ready;

    always_comb begin
        if (load)           valid_next = 1'b1;
        else if (out_ready) valid_next = 1'b0;
        else                valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/gzip_header_trailer_parser.sv @@
// Parses one gzip member (RFC 1952) a byte per cycle unless m_tready stalls:
// checks magic and method, rejects reserved flags, skips the fixed header,
// FEXTRA, FNAME, FCOMMENT and FHCRC, flags payload bytes and captures the
// trailer CRC32 and ISIZE. Each input byte gives exactly one result
// transaction. Throughput is one byte per cycle unless m_tready stalls.
// The input and result registers sit around the combinational phase logic.
// Write cfg_wdata (total member length, trailer included) while the block is
// idle; set s_tuser on byte 0 of each member to restart parsing. m_tlast marks
// the last trailer byte or the byte that latched an error.
module gzip_header_trailer_parser #(
    parameter int LENGTH_BITS = gzhp_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: member_length
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] first_byte
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [7:0] payload_byte, [39:8] payload_offset,
                                    // [43:40] latched_err, [75:44] expected_crc,
                                    // [107:76] expected_size, [111:108] zero
    output logic         m_tuser,   // [0] payload_valid
    output logic         m_tlast    // member_done
);
    import gzhp_pkg::*;

    logic [LENGTH_BITS-1:0] mlen_reg;
    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_byte_reg;
    logic                   in_first_reg;
    logic                   s_accept;
    logic                   advance;
    logic                   can_load;
    gzhp_result_t           step_result;
    gzhp_result_t           out_data;

    // member length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mlen_reg <= '0;
        end else if (cfg_we) begin
            mlen_reg <= LENGTH_BITS'(cfg_wdata);
        end
    end

    // input register handshake
    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept)     in_valid_next = 1'b1;
        else if (advance) in_valid_next = 1'b0;
        else              in_valid_next = in_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    // phase logic and parser state
    gzhp_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .data_byte    (in_byte_reg),
        .first_byte   (in_first_reg),
        .member_length(mlen_reg),
        .result       (step_result)
    );

    // result register
    gzhp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .load_data(step_result),
        .can_load (can_load),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (out_data)
    );

    assign m_tdata = {4'd0, out_data.expected_size, out_data.expected_crc,
                      out_data.latched_err, out_data.payload_offset,
                      out_data.payload_byte};
    assign m_tuser = out_data.payload_valid;
    assign m_tlast = out_data.member_done;

endmodule
